// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== hw/rtl/wls_pkg.sv =====
// Package with the shared constants and types of the weighted length selector.
`default_nettype none
package wls_pkg;
  localparam int unsigned TableDepth = 64;
  localparam int unsigned LenW = 32;
  localparam int unsigned WgtW = 32;
  localparam int unsigned RndW = 31;
  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_DRAW = 1'b1;

  // Data handed from one cell to the next during a walk.
  typedef struct packed {
    logic            active;
    logic            found;
    logic [63:0]     run;
    logic [LenW-1:0] sel;
  } wls_walk_t;
endpackage
`default_nettype wire

// ===== hw/rtl/wls_cell.sv =====
// One table cell: holds an entry and extends the cumulative walk by one step.
`default_nettype none
module wls_cell (
  input  wire                       clk_i,
  input  wire                       wr_i,
  input  wire  [wls_pkg::LenW-1:0]  len_i,
  input  wire  [wls_pkg::WgtW-1:0]  wgt_i,
  input  wire                       in_cnt_i,
  input  wire  [63:0]               pos_i,
  input  wls_pkg::wls_walk_t        walk_i,
  output wls_pkg::wls_walk_t        walk_o
);
  import wls_pkg::*;
  logic [LenW-1:0] len_q;
  logic [WgtW-1:0] wgt_q;
  logic [63:0]     run_d;

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      len_q <= len_i;
      wgt_q <= wgt_i;
    end
  end

  // Cells beyond the entry count add no weight, so the walk passes through.
  assign run_d = walk_i.run + (in_cnt_i ? {32'd0, wgt_q} : 64'd0);

  always_ff @(posedge clk_i) begin
    walk_o.active <= walk_i.active;
    walk_o.run    <= run_d;
    if (walk_i.active && !walk_i.found && in_cnt_i && (pos_i < run_d)) begin
      walk_o.found <= 1'b1;
      walk_o.sel   <= len_q;
    end else begin
      walk_o.found <= walk_i.found;
      walk_o.sel   <= walk_i.sel;
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/wls_mod.sv =====
// Restoring modulo unit: one quotient bit per cycle.
`default_nettype none
module wls_mod (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          start_i,
  input  wire  [30:0]  num_i,
  input  wire  [63:0]  den_i,
  output logic         done_o,
  output logic [63:0]  rem_o
);
  import wls_pkg::*;
  logic [4:0]  cnt_q;
  logic        busy_q;
  logic [30:0] num_q;
  logic [63:0] rem_q;
  logic [64:0] shifted;

  assign shifted = {rem_q, num_q[30]};
  assign rem_o   = rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 5'd30;
      end else if (busy_q) begin
        if (cnt_q == 5'd0) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
        cnt_q <= cnt_q - 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[29:0], 1'b0};
      if (shifted >= {1'b0, den_i}) begin
        rem_q <= 64'(shifted - {1'b0, den_i});
      end else begin
        rem_q <= shifted[63:0];
      end
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/weighted_length_selector_unit.sv =====
// Top level of the weighted length selector: control, statistics and cell chain.
//
//   Channel | Signals                                         | Direction
//   input   | in_valid_i, in_stall_o, op_i, entry_length_i,   | into block
//           | entry_weight_i, random_value_i                  |
//   output  | out_valid_o, out_stall_i, selected_length_o,    | out of block
//           | entry_count_o, min_length_o, max_length_o,      |
//           | table_full_o                                    |
//
// An add, and a draw on a table with fewer than two entries, loads the result
// register in the execute state that follows acceptance. A draw with two or
// more entries first runs the modulo unit (one quotient bit per cycle), then
// walks the cell chain, and loads the result register after that walk. One
// item is worked on at a time, and the input stalls from acceptance until the
// result moves into the output register. Reset clears the count, the weight
// total and the length bounds; the table contents need no reset. A new item
// may be accepted while a stalled result waits in the output register.
`default_nettype none
module weighted_length_selector_unit #(
  parameter int unsigned TABLE_DEPTH = wls_pkg::TableDepth
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              in_valid_i,
  output logic                             in_stall_o,
  input  wire                              op_i,
  input  wire  [wls_pkg::LenW-1:0]         entry_length_i,
  input  wire  [wls_pkg::WgtW-1:0]         entry_weight_i,
  input  wire  [wls_pkg::RndW-1:0]         random_value_i,
  output logic                             out_valid_o,
  input  wire                              out_stall_i,
  output logic [wls_pkg::LenW-1:0]         selected_length_o,
  output logic [$clog2(TABLE_DEPTH+1)-1:0] entry_count_o,
  output logic [wls_pkg::LenW-1:0]         min_length_o,
  output logic [wls_pkg::LenW-1:0]         max_length_o,
  output logic                             table_full_o
);
  import wls_pkg::*;
  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned IdxW = $clog2(TABLE_DEPTH);
  localparam int unsigned WalkW = $clog2(TABLE_DEPTH + 2);

  typedef enum logic [2:0] {
    ST_IDLE, ST_EXEC, ST_MOD, ST_WALK, ST_DONE
  } state_e;

  state_e          state_q;
  logic            pend_q;
  logic            op_q;
  logic [LenW-1:0] len_q;
  logic [WgtW-1:0] wgt_q;
  logic [RndW-1:0] rnd_q;
  logic [CntW-1:0] count_q;
  logic [63:0]     total_q;
  logic [LenW-1:0] least_q;
  logic [LenW-1:0] great_q;
  logic [LenW-1:0] first_q;
  logic [WalkW-1:0] walk_cnt_q;
  logic            mod_start;
  logic            mod_done;
  logic [63:0]     mod_rem;
  logic [63:0]     pos_q;
  logic [LenW-1:0] res_sel;
  logic            res_full;
  logic            accept;
  logic            wr_en;
  wls_walk_t       walk_head;
  wls_walk_t       walk [TABLE_DEPTH+1];

  // The input register frees when the result moves into the output register.
  assign in_stall_o = pend_q;
  assign accept     = in_valid_i && !pend_q;
  assign wr_en      = (state_q == ST_EXEC) && (op_q == OP_ADD) &&
                      (count_q < CntW'(TABLE_DEPTH));
  assign mod_start  = (state_q == ST_EXEC) && (op_q == OP_DRAW) &&
                      (count_q > CntW'(1));

  wls_mod u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mod_start),
    .num_i   (rnd_q),
    .den_i   (total_q),
    .done_o  (mod_done),
    .rem_o   (mod_rem)
  );

  assign walk_head.active = (state_q == ST_WALK) && (walk_cnt_q == '0);
  assign walk_head.found  = 1'b0;
  assign walk_head.run    = '0;
  assign walk_head.sel    = '0;
  assign walk[0]          = walk_head;

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    wls_cell u_cell (
      .clk_i    (clk_i),
      .wr_i     (wr_en && (count_q[IdxW-1:0] == IdxW'(g))),
      .len_i    (len_q),
      .wgt_i    ((wgt_q == '0) ? WgtW'(1) : wgt_q),
      .in_cnt_i (CntW'(g) < count_q),
      .pos_i    (pos_q),
      .walk_i   (walk[g]),
      .walk_o   (walk[g+1])
    );
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= op_i;
      len_q <= entry_length_i;
      wgt_q <= entry_weight_i;
      rnd_q <= random_value_i;
    end
    if (mod_done) begin
      pos_q <= mod_rem;
    end
    if (wr_en && (count_q == '0)) begin
      first_q <= len_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      pend_q     <= 1'b0;
      count_q    <= '0;
      total_q    <= '0;
      least_q    <= '1;
      great_q    <= '0;
      walk_cnt_q <= '0;
      res_sel    <= '0;
      res_full   <= 1'b0;
    end else begin
      if (accept) begin
        pend_q <= 1'b1;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (pend_q || accept) begin
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (op_q == OP_ADD) begin
            if (wr_en) begin
              count_q <= count_q + CntW'(1);
              total_q <= total_q + {32'd0, ((wgt_q == '0) ? WgtW'(1) : wgt_q)};
              if (len_q > great_q) great_q <= len_q;
              if (len_q < least_q) least_q <= len_q;
              res_full <= 1'b0;
            end else begin
              res_full <= 1'b1;
            end
            res_sel  <= '0;
            state_q  <= ST_DONE;
          end else if (count_q == '0) begin
            res_sel  <= '0;
            res_full <= 1'b0;
            state_q  <= ST_DONE;
          end else if (count_q == CntW'(1)) begin
            res_sel  <= first_q;
            res_full <= 1'b0;
            state_q  <= ST_DONE;
          end else begin
            state_q <= ST_MOD;
          end
        end
        ST_MOD: begin
          if (mod_done) begin
            walk_cnt_q <= '0;
            state_q    <= ST_WALK;
          end
        end
        ST_WALK: begin
          walk_cnt_q <= walk_cnt_q + WalkW'(1);
          if (walk_cnt_q == WalkW'(TABLE_DEPTH)) begin
            res_sel  <= walk[TABLE_DEPTH].found ? walk[TABLE_DEPTH].sel : '0;
            res_full <= 1'b0;
            state_q  <= ST_DONE;
          end
        end
        ST_DONE: begin
          // Leave once the output register is free or its previous result is being taken.
          if (!out_valid_o || !out_stall_i) begin
            state_q <= ST_IDLE;
            pend_q  <= 1'b0;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Output register; loaded in ST_DONE when free.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (state_q == ST_DONE && (!out_valid_o || !out_stall_i)) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DONE && (!out_valid_o || !out_stall_i)) begin
      selected_length_o <= res_sel;
      entry_count_o     <= count_q;
      min_length_o      <= least_q;
      max_length_o      <= great_q;
      table_full_o      <= res_full;
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/wls_checker.sv =====
// Port-level checker for the weighted length selector, with its bind.
`default_nettype none
`include "assert_macros.svh"
module wls_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        in_valid_i,
  input wire        in_stall_o,
  input wire        out_valid_o,
  input wire        out_stall_i,
  input wire [31:0] selected_length_o,
  input wire [31:0] min_length_o,
  input wire [31:0] max_length_o,
  input wire        table_full_o
);
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)
  `ASSERT_NEXT(a_sel_hold, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(selected_length_o))
  `ASSERT_IMPL(a_full_no_sel, clk_i, rst_ni, out_valid_o && table_full_o, selected_length_o == 32'd0)
  `ASSERT_IMPL(a_bounds, clk_i, rst_ni, out_valid_o && (max_length_o != 32'd0), min_length_o <= max_length_o)
  `ASSERT_NEXT(a_busy, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)
endmodule

bind weighted_length_selector_unit wls_checker u_wls_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_stall_o        (in_stall_o),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .selected_length_o (selected_length_o),
  .min_length_o      (min_length_o),
  .max_length_o      (max_length_o),
  .table_full_o      (table_full_o)
);
`default_nettype wire

// ===== bench/weighted_length_selector_unit_tb.sv =====
// Self-checking bench for the weighted length selector: directed and random adds and draws.
`timescale 1ns / 1ps
`default_nettype none
module weighted_length_selector_unit_tb;
  import wls_pkg::*;

  localparam int unsigned Depth = TableDepth;
  localparam int unsigned WatchLimit = 20000;

  typedef struct packed {
    logic [LenW-1:0] sel;
    logic [6:0]      cnt;
    logic [LenW-1:0] lo;
    logic [LenW-1:0] hi;
    logic            full;
  } selection_t;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            in_valid_i = 1'b0;
  logic            in_stall_o;
  logic            op_i = OP_ADD;
  logic [LenW-1:0] entry_length_i = '0;
  logic [WgtW-1:0] entry_weight_i = '0;
  logic [RndW-1:0] random_value_i = '0;
  logic            out_valid_o;
  logic            out_stall_i = 1'b0;
  logic [LenW-1:0] selected_length_o;
  logic [6:0]      entry_count_o;
  logic [LenW-1:0] min_length_o;
  logic [LenW-1:0] max_length_o;
  logic            table_full_o;

  // Mirror of the table held by the block.
  logic [LenW-1:0] len_mirror [Depth];
  logic [WgtW-1:0] wgt_mirror [Depth];
  int unsigned     held_entries;
  logic [63:0]     weight_sum;
  logic [LenW-1:0] least_len;
  logic [LenW-1:0] greatest_len;

  selection_t pending_selections[$];
  int unsigned errors = 0;
  int unsigned idle_cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_receiver = 1'b0;

  always #5 clk_i = ~clk_i;

  weighted_length_selector_unit u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .op_i, .entry_length_i,
    .entry_weight_i, .random_value_i, .out_valid_o, .out_stall_i,
    .selected_length_o, .entry_count_o, .min_length_o, .max_length_o, .table_full_o
  );

  // Predict one item's result and advance the mirrored table.
  function automatic selection_t predict_selection(logic op, logic [LenW-1:0] len,
                                                   logic [WgtW-1:0] wgt,
                                                   logic [RndW-1:0] rnd);
    selection_t  res;
    logic [63:0] pos;
    logic [63:0] run;
    res = '0;
    if (op == OP_ADD) begin
      if (held_entries >= Depth) begin
        res.full = 1'b1;
      end else begin
        if (wgt == '0) wgt = WgtW'(1);
        len_mirror[held_entries] = len;
        wgt_mirror[held_entries] = wgt;
        held_entries++;
        weight_sum += 64'(wgt);
        if (len > greatest_len) greatest_len = len;
        if (len < least_len) least_len = len;
      end
    end else if (held_entries == 1) begin
      res.sel = len_mirror[0];
    end else if (held_entries > 1) begin
      // The draw reduces the random value and takes the first entry whose
      // cumulative weight passes it.
      pos = 64'(rnd) % weight_sum;
      run = '0;
      for (int i = 0; i < held_entries; i++) begin
        run += 64'(wgt_mirror[i]);
        if (pos < run) begin
          res.sel = len_mirror[i];
          break;
        end
      end
    end
    res.cnt = 7'(held_entries);
    res.lo = least_len;
    res.hi = greatest_len;
    return res;
  endfunction

  // Offer one item, wait until the block takes it, then queue its result.
  // The block stalls right after an accept, so the extra wait costs nothing.
  task automatic send_item(logic op, logic [LenW-1:0] len, logic [WgtW-1:0] wgt,
                           logic [RndW-1:0] rnd);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) @(posedge clk_i);
    in_valid_i <= 1'b1;
    op_i <= op;
    entry_length_i <= len;
    entry_weight_i <= wgt;
    random_value_i <= rnd;
    do @(posedge clk_i); while (in_stall_o);
    pending_selections.push_back(predict_selection(op, len, wgt, rnd));
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain_results();
    while (pending_selections.size() != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
  endtask

  // Reset brings an empty table back; the block is reset only once, so the
  // mirror is cleared here once, before reset is released.
  task automatic clear_mirror();
    held_entries = 0;
    weight_sum = '0;
    least_len = '1;
    greatest_len = '0;
  endtask

  task automatic send_draw();
    send_item(OP_DRAW, LenW'($urandom), WgtW'($urandom), RndW'($urandom));
  endtask

  // Directed: empty draw, single entry, extremes of length and weight.
  task automatic test_directed();
    send_item(OP_DRAW, '1, '1, '1);
    send_item(OP_ADD, 32'h1234_5678, '0, '0);
    send_item(OP_DRAW, '0, '0, '1);
    send_item(OP_ADD, '0, '1, '0);
    send_item(OP_ADD, '1, '0, '1);
    send_item(OP_DRAW, '0, '0, '0);
    send_item(OP_DRAW, '0, '0, '1);
    send_item(OP_DRAW, '1, '1, 31'h5555_5555);
    send_item(OP_DRAW, '1, '1, 31'h2AAA_AAAA);
  endtask

  // Fill the table with random entries, half with small weights, and draw often.
  task automatic test_fill_and_draw(int unsigned n_items);
    for (int unsigned k = 0; k < n_items; k++) begin
      if ($urandom_range(3) == 0 && held_entries < Depth + 2) begin
        send_item(OP_ADD, LenW'($urandom),
                  $urandom_range(1) ? WgtW'($urandom_range(8)) : WgtW'($urandom),
                  RndW'($urandom));
      end else begin
        send_draw();
      end
    end
  endtask

  // Receiver holds off for a long time while items keep coming.
  task automatic test_backpressure();
    fork
      begin
        hold_receiver = 1'b1;
        repeat (600) @(posedge clk_i);
        hold_receiver = 1'b0;
      end
      repeat (6) send_draw();
    join
    drain_results();
  endtask

  always @(posedge clk_i) begin
    out_stall_i <= hold_receiver ||
                   (recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
  end

  // Compare each accepted result with the oldest prediction.
  always @(posedge clk_i) begin
    selection_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_selections.size() == 0) begin
        $error("unexpected result item");
        errors++;
      end else begin
        want = pending_selections.pop_front();
        if (selected_length_o !== want.sel) begin
          $error("selected_length exp %h got %h", want.sel, selected_length_o);
          errors++;
        end
        if (entry_count_o !== want.cnt) begin
          $error("entry_count exp %0d got %0d", want.cnt, entry_count_o);
          errors++;
        end
        if (min_length_o !== want.lo) begin
          $error("min_length exp %h got %h", want.lo, min_length_o);
          errors++;
        end
        if (max_length_o !== want.hi) begin
          $error("max_length exp %h got %h", want.hi, max_length_o);
          errors++;
        end
        if (table_full_o !== want.full) begin
          $error("table_full exp %0b got %0b", want.full, table_full_o);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles with no accepted item on either channel.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchLimit) begin
        $display("FAIL weighted_length_selector_unit");
        $finish;
      end
    end
  end

  initial begin
    clear_mirror();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_fill_and_draw(150);
    // The sender waits here for every pending result.
    drain_results();
    send_idle_pct = 61;
    test_fill_and_draw(300);
    test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 61;
    test_fill_and_draw(300);
    send_idle_pct = 10;
    recv_stall_pct = 10;
    test_fill_and_draw(400);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_fill_and_draw(350);
    drain_results();
    if (errors == 0) begin
      $display("PASS weighted_length_selector_unit");
    end else begin
      $display("FAIL weighted_length_selector_unit");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/wls_pkg.sv
hw/rtl/wls_cell.sv
hw/rtl/wls_mod.sv
hw/rtl/weighted_length_selector_unit.sv
hw/rtl/wls_checker.sv
bench/weighted_length_selector_unit_tb.sv
